// ----- rtl/dfup_pkg.sv -----
// Shared types and constants for the DLE framed uplink parser.
// Used by every module of the block except dfup_ram; depends on nothing.
package dfup_pkg;

    localparam int COMMAND_BYTES_DEF = 32;
    localparam int TABLE_ENTRIES     = 256;
    localparam int QUEUE_DEPTH_DEF   = 2;

    localparam logic [7:0] DLE_BYTE = 8'h10;
    localparam logic [7:0] ETX_BYTE = 8'h03;
    localparam logic [7:0] ID_POS   = 8'h10;
    localparam logic [7:0] ID_TIME  = 8'h11;
    localparam logic [7:0] ID_ALT   = 8'h12;
    localparam logic [7:0] ID_REQ   = 8'h13;
    localparam logic [7:0] ID_CMD   = 8'h14;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_SET  = 1'b1;

    localparam logic [2:0] KIND_POS  = 3'd0;
    localparam logic [2:0] KIND_TIME = 3'd1;
    localparam logic [2:0] KIND_ALT  = 3'd2;
    localparam logic [2:0] KIND_REQ  = 3'd3;
    localparam logic [2:0] KIND_CMD  = 3'd4;

    localparam logic [1:0] JOB_SET   = 2'd0;
    localparam logic [1:0] JOB_FRAME = 2'd1;
    localparam logic [1:0] JOB_FRAG  = 2'd2;

    typedef struct packed {
        logic [1:0]  jtype;
        logic [2:0]  kind;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
        logic [15:0] week;
        logic [7:0]  arg0;
        logic [7:0]  arg1;
    } t_job;

endpackage

// ----- rtl/dfup_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; no package dependency.
module dfup_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/dfup_queue.sv -----
// Short in-order job queue between the parser front and the execution back.
// Depends on dfup_pkg for the job type.
module dfup_queue #(
    parameter int DEPTH = dfup_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dfup_pkg::t_job    i_data,
    input  logic              i_pop,
    output dfup_pkg::t_job    o_data,
    output logic              o_empty,
    output logic              o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dfup_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ----- rtl/dfup_front.sv -----
// Parser front: accepts items, tracks DLE framing and collects message bodies.
// Pushes one job per decoded frame, fragment or length write; uses dfup_pkg.
module dfup_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_op,
    input  logic [7:0]     i_rx_byte,
    input  logic [7:0]     i_cmd_id,
    input  logic [7:0]     i_cmd_length,
    input  logic           i_full,
    output logic           o_push,
    output dfup_pkg::t_job o_job
);

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_ID   = 3'd1;
    localparam logic [2:0] PH_POS  = 3'd2;
    localparam logic [2:0] PH_TIME = 3'd3;
    localparam logic [2:0] PH_ALT  = 3'd4;
    localparam logic [2:0] PH_REQ  = 3'd5;
    localparam logic [2:0] PH_CMD  = 3'd6;

    function automatic logic [3:0] body_len(input logic [2:0] ph);
        logic [3:0] len;
        case (ph)
            PH_POS:  len = 4'd15;
            PH_TIME: len = 4'd15;
            PH_ALT:  len = 4'd7;
            PH_REQ:  len = 4'd1;
            default: len = 4'd4;
        endcase
        return len;
    endfunction

    logic [2:0]     r_phase;
    logic [2:0]     n_phase;
    logic [3:0]     r_count;
    logic [3:0]     n_count;
    logic [7:0]     r_body [15];
    logic           body_we;
    logic           accept;
    dfup_pkg::t_job job;
    logic           push;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        body_we = 1'b0;
        push    = 1'b0;
        job     = '0;
        if (accept) begin
            if (i_op == dfup_pkg::OP_SET) begin
                push       = 1'b1;
                job.jtype  = dfup_pkg::JOB_SET;
                job.arg0   = i_cmd_id;
                job.arg1   = i_cmd_length;
            end else begin
                unique case (r_phase)
                    PH_HUNT: begin
                        if (i_rx_byte == dfup_pkg::DLE_BYTE) begin
                            n_phase = PH_ID;
                        end
                    end
                    PH_ID: begin
                        n_count = '0;
                        case (i_rx_byte)
                            dfup_pkg::ID_POS:  n_phase = PH_POS;
                            dfup_pkg::ID_TIME: n_phase = PH_TIME;
                            dfup_pkg::ID_ALT:  n_phase = PH_ALT;
                            dfup_pkg::ID_REQ:  n_phase = PH_REQ;
                            dfup_pkg::ID_CMD:  n_phase = PH_CMD;
                            default:           n_phase = PH_HUNT;
                        endcase
                    end
                    default: begin
                        body_we = 1'b1;
                        if (r_count + 4'd1 == body_len(r_phase)) begin
                            n_phase = PH_HUNT;
                            n_count = '0;
                            if (i_rx_byte == dfup_pkg::ETX_BYTE) begin
                                push      = 1'b1;
                                job.jtype = dfup_pkg::JOB_FRAME;
                                case (r_phase)
                                    PH_POS: begin
                                        job.kind   = dfup_pkg::KIND_POS;
                                        job.word_a = {r_body[3], r_body[2],
                                                      r_body[1], r_body[0]};
                                        job.word_b = {r_body[7], r_body[6],
                                                      r_body[5], r_body[4]};
                                        job.word_c = {r_body[11], r_body[10],
                                                      r_body[9], r_body[8]};
                                    end
                                    PH_TIME: begin
                                        job.kind   = dfup_pkg::KIND_TIME;
                                        job.word_a = {r_body[3], r_body[2],
                                                      r_body[1], r_body[0]};
                                        job.week   = {r_body[5], r_body[4]};
                                        job.word_b = {r_body[9], r_body[8],
                                                      r_body[7], r_body[6]};
                                        job.word_c = {r_body[13], r_body[12],
                                                      r_body[11], r_body[10]};
                                    end
                                    PH_ALT: begin
                                        job.kind   = dfup_pkg::KIND_ALT;
                                        job.word_a = {16'd0, r_body[0], r_body[1]};
                                        job.word_b = {16'd0, r_body[2], r_body[3]};
                                        job.word_c = {16'd0, r_body[4], r_body[5]};
                                    end
                                    PH_REQ: begin
                                        job.kind = dfup_pkg::KIND_REQ;
                                    end
                                    default: begin
                                        job.jtype = dfup_pkg::JOB_FRAG;
                                        job.arg0  = r_body[1];
                                        job.arg1  = r_body[2];
                                    end
                                endcase
                            end
                        end else begin
                            n_count = r_count + 4'd1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (body_we) begin
            r_body[r_count] <= i_rx_byte;
        end
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    assign o_push = push;
    assign o_job  = job;

endmodule

// ----- rtl/dfup_back.sv -----
// Execution back: drains jobs, keeps the length table and the command buffer,
// and drives the result register. Uses dfup_pkg and dfup_ram.
module dfup_back #(
    parameter int COMMAND_BYTES = dfup_pkg::COMMAND_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dfup_pkg::t_job i_job,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [2:0]     o_kind,
    output logic [31:0]    o_word_a,
    output logic [31:0]    o_word_b,
    output logic [31:0]    o_word_c,
    output logic [15:0]    o_week,
    output logic [7:0]     o_command_byte,
    output logic           o_command_known,
    output logic           o_last
);

    localparam int AW  = $clog2(COMMAND_BYTES);
    localparam int LW  = $clog2(COMMAND_BYTES + 1);
    localparam int TAW = $clog2(dfup_pkg::TABLE_ENTRIES);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_LOOKUP  = 2'd1;
    localparam logic [1:0] ST_EMIT_RD = 2'd2;
    localparam logic [1:0] ST_EMIT_WR = 2'd3;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic [LW-1:0] r_len;
    logic [LW-1:0] n_len;
    logic [LW-1:0] r_idx;
    logic [LW-1:0] n_idx;
    logic [7:0]    r_first;
    logic [7:0]    n_first;
    logic          r_known;
    logic          n_known;
    logic [dfup_pkg::TABLE_ENTRIES-1:0] r_tvalid;

    logic          tbl_we;
    logic [TAW-1:0] tbl_raddr;
    logic [7:0]    tbl_rdata;
    logic          cmd_we;
    logic [7:0]    cmd_rdata;
    logic [AW-1:0] cmd_raddr;

    logic          slot_free;
    logic          load_frame;
    logic          load_cmd;
    logic          cmd_last;
    logic          pop;

    logic          r_out_valid;
    logic [2:0]    r_kind;
    logic [31:0]   r_word_a;
    logic [31:0]   r_word_b;
    logic [31:0]   r_word_c;
    logic [15:0]   r_week;
    logic [7:0]    r_cmd_byte;
    logic          r_cmd_known;
    logic          r_last;

    assign slot_free = !r_out_valid || i_ready;
    assign cmd_last  = (r_idx + LW'(1) == r_len);
    assign tbl_raddr = (r_len == '0) ? i_job.arg1 : r_first;
    assign cmd_raddr = r_idx[AW-1:0];

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_idx      = r_idx;
        n_first    = r_first;
        n_known    = r_known;
        pop        = 1'b0;
        tbl_we     = 1'b0;
        cmd_we     = 1'b0;
        load_frame = 1'b0;
        load_cmd   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    case (i_job.jtype)
                        dfup_pkg::JOB_SET: begin
                            pop    = 1'b1;
                            tbl_we = 1'b1;
                        end
                        dfup_pkg::JOB_FRAME: begin
                            if (slot_free) begin
                                pop        = 1'b1;
                                load_frame = 1'b1;
                            end
                        end
                        default: begin
                            pop = 1'b1;
                            if (i_job.arg0 != 8'(r_len) ||
                                r_len >= LW'(COMMAND_BYTES)) begin
                                n_len = '0;
                            end else begin
                                cmd_we  = 1'b1;
                                n_len   = r_len + LW'(1);
                                n_first = tbl_raddr;
                                n_state = ST_LOOKUP;
                            end
                        end
                    endcase
                end
            end
            ST_LOOKUP: begin
                if (r_tvalid[r_first] && tbl_rdata != 8'(r_len)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_known = r_tvalid[r_first];
                    n_idx   = '0;
                    n_state = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_WR;
            end
            default: begin
                if (slot_free) begin
                    load_cmd = 1'b1;
                    if (cmd_last) begin
                        n_len   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + LW'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end
        endcase
    end

    dfup_ram #(
        .WIDTH (8),
        .DEPTH (dfup_pkg::TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (i_job.arg0),
        .i_wdata (i_job.arg1),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    dfup_ram #(
        .WIDTH (8),
        .DEPTH (COMMAND_BYTES)
    ) u_command (
        .i_clk   (i_clk),
        .i_we    (cmd_we),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (i_job.arg1),
        .i_raddr (cmd_raddr),
        .o_rdata (cmd_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (load_frame) begin
            r_kind      <= i_job.kind;
            r_word_a    <= i_job.word_a;
            r_word_b    <= i_job.word_b;
            r_word_c    <= i_job.word_c;
            r_week      <= i_job.week;
            r_cmd_byte  <= '0;
            r_cmd_known <= 1'b0;
            r_last      <= 1'b1;
        end else if (load_cmd) begin
            r_kind      <= dfup_pkg::KIND_CMD;
            r_word_a    <= '0;
            r_word_b    <= '0;
            r_word_c    <= '0;
            r_week      <= '0;
            r_cmd_byte  <= cmd_rdata;
            r_cmd_known <= r_known;
            r_last      <= cmd_last;
        end
        r_idx   <= n_idx;
        r_first <= n_first;
        r_known <= n_known;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_tvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            if (tbl_we) begin
                r_tvalid[i_job.arg0] <= 1'b1;
            end
            if (load_frame || load_cmd) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_pop           = pop;
    assign o_valid         = r_out_valid;
    assign o_kind          = r_kind;
    assign o_word_a        = r_word_a;
    assign o_word_b        = r_word_b;
    assign o_word_c        = r_word_c;
    assign o_week          = r_week;
    assign o_command_byte  = r_cmd_byte;
    assign o_command_known = r_cmd_known;
    assign o_last          = r_last;

    a_len_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(COMMAND_BYTES))
        else $error("command length beyond buffer");

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT_RD || r_state == ST_EMIT_WR) |-> r_idx < r_len)
        else $error("emit index outside the held command");

    a_lookup_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && n_state == ST_LOOKUP) |-> cmd_we && pop)
        else $error("lookup started without storing a fragment");

endmodule

// ----- rtl/dle_framed_uplink_parser_unit.sv -----
// Top level of the DLE framed uplink parser: front, job queue and back.
// Depends on dfup_pkg, dfup_front, dfup_queue and dfup_back.
// Input: one item per cycle while the job queue has room; it stalls when the queue is full.
// A frame is queued when its ETX item is accepted, then loaded into the output register.
// A finished command runs through LOOKUP, then EMIT_RD and EMIT_WR for each byte.
// Synchronous reset clears framing, assembly and the length table valid bits.
module dle_framed_uplink_parser_unit #(
    parameter int COMMAND_BYTES = dfup_pkg::COMMAND_BYTES_DEF,
    parameter int QUEUE_DEPTH   = dfup_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_cmd_id,
    input  logic [7:0]  i_cmd_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [31:0] o_word_a,
    output logic [31:0] o_word_b,
    output logic [31:0] o_word_c,
    output logic [15:0] o_week,
    output logic [7:0]  o_command_byte,
    output logic        o_command_known,
    output logic        o_last
);

    dfup_pkg::t_job push_job;
    dfup_pkg::t_job head_job;
    logic           push;
    logic           pop;
    logic           empty;
    logic           full;

    dfup_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_rx_byte    (i_rx_byte),
        .i_cmd_id     (i_cmd_id),
        .i_cmd_length (i_cmd_length),
        .i_full       (full),
        .o_push       (push),
        .o_job        (push_job)
    );

    dfup_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_data  (head_job),
        .o_empty (empty),
        .o_full  (full)
    );

    dfup_back #(
        .COMMAND_BYTES (COMMAND_BYTES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (head_job),
        .i_empty         (empty),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_word_a        (o_word_a),
        .o_word_b        (o_word_b),
        .o_word_c        (o_word_c),
        .o_week          (o_week),
        .o_command_byte  (o_command_byte),
        .o_command_known (o_command_known),
        .o_last          (o_last)
    );

endmodule

// ----- tb/dle_framed_uplink_parser_unit_tb.sv -----
// Self-checking bench for dle_framed_uplink_parser_unit: directed rows, then random traffic.
// A behavioural parser follows every item; results are checked against it or a table row.
// Depends on dfup_pkg and the RTL of the block only.
module dle_framed_uplink_parser_unit_tb;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int TOTAL_ITEMS    = 230;
    localparam int LONG_FRAGMENTS = 12;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 40;
    localparam int CMD_BYTES      = dfup_pkg::COMMAND_BYTES_DEF;

    typedef enum logic [2:0] {
        ST_HUNT, ST_ID, ST_POSITION, ST_TIME, ST_ALT, ST_REQUEST, ST_FRAGMENT
    } t_parse_state;

    typedef enum logic [1:0] {BY_MODEL, NO_RESULT, ONE_RESULT} t_expect_mode;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
        logic [15:0] week;
        logic [7:0]  command_byte;
        logic        command_known;
        logic        last;
    } t_uplink_result;

    typedef struct packed {
        logic           op;
        logic [7:0]     rx_byte;
        logic [7:0]     cmd_id;
        logic [7:0]     cmd_length;
        t_expect_mode   mode;
        t_uplink_result result;
    } t_directed_row;

    localparam t_uplink_result RES_NONE    = '0;
    localparam t_uplink_result RES_REQUEST =
        '{dfup_pkg::KIND_REQ, 32'h0, 32'h0, 32'h0, 16'h0, 8'h00, 1'b0, 1'b1};
    localparam t_uplink_result RES_ALT =
        '{dfup_pkg::KIND_ALT, 32'h0000_1234, 32'h0000_5678, 32'h0000_9ABC,
          16'h0, 8'h00, 1'b0, 1'b1};
    localparam t_uplink_result RES_CMD_AB =
        '{dfup_pkg::KIND_CMD, 32'h0, 32'h0, 32'h0, 16'h0, 8'hAB, 1'b0, 1'b1};

    localparam t_directed_row DIRECTED_ROWS [28] = '{
        '{dfup_pkg::OP_BYTE, 8'h00,              8'h00, 8'h00, NO_RESULT,  RES_NONE},
        '{dfup_pkg::OP_BYTE, dfup_pkg::DLE_BYTE, 8'hFF, 8'hFF, NO_RESULT,  RES_NONE},
        '{dfup_pkg::OP_BYTE, dfup_pkg::ID_REQ,   8'h00, 8'h00, NO_RESULT,  RES_NONE},
        '{dfup_pkg::OP_BYTE, dfup_pkg::ETX_BYTE, 8'hFF, 8'hFF, ONE_RESULT, RES_REQUEST},
        '{dfup_pkg::OP_BYTE, dfup_pkg::DLE_BYTE, 8'h00, 8'h00, NO_RESULT,  RES_NONE},
        '{dfup_pkg::OP_BYTE, dfup_pkg::ID_REQ,   8'hFF, 8'hFF, NO_RESULT,  RES_NONE},
        '{dfup_pkg::OP_BYTE, 8'hFF,              8'h00, 8'h00, NO_RESULT,  RES_NONE},
        '{dfup_pkg::OP_BYTE, dfup_pkg::DLE_BYTE, 8'hA5, 8'h5A, NO_RESULT,  RES_NONE},
        '{dfup_pkg::OP_BYTE, 8'h55,              8'h5A, 8'hA5, NO_RESULT,  RES_NONE},
        '{dfup_pkg::OP_SET,  8'hFF,              8'hFF, 8'h00, NO_RESULT,  RES_NONE},
        '{dfup_pkg::OP_SET,  8'h00,              8'h00, 8'hFF, NO_RESULT,  RES_NONE},
        '{dfup_pkg::OP_BYTE, dfup_pkg::DLE_BYTE, 8'h00, 8'h00, NO_RESULT,  RES_NONE},
        '{dfup_pkg::OP_BYTE, dfup_pkg::ID_CMD,   8'h00, 8'h00, NO_RESULT,  RES_NONE},
        '{dfup_pkg::OP_BYTE, 8'hFF,              8'h00, 8'h00, BY_MODEL,   RES_NONE},
        '{dfup_pkg::OP_BYTE, 8'h00,              8'h00, 8'h00, BY_MODEL,   RES_NONE},
        '{dfup_pkg::OP_BYTE, 8'hAB,              8'h00, 8'h00, BY_MODEL,   RES_NONE},
        '{dfup_pkg::OP_BYTE, dfup_pkg::ETX_BYTE, 8'h00, 8'h00, ONE_RESULT, RES_CMD_AB},
        '{dfup_pkg::OP_BYTE, dfup_pkg::DLE_BYTE, 8'h00, 8'h00, NO_RESULT,  RES_NONE},
        '{dfup_pkg::OP_BYTE, dfup_pkg::ID_ALT,   8'h00, 8'h00, NO_RESULT,  RES_NONE},
        '{dfup_pkg::OP_BYTE, 8'h12,              8'h00, 8'h00, BY_MODEL,   RES_NONE},
        '{dfup_pkg::OP_BYTE, 8'h34,              8'h00, 8'h00, BY_MODEL,   RES_NONE},
        '{dfup_pkg::OP_BYTE, 8'h56,              8'h00, 8'h00, BY_MODEL,   RES_NONE},
        '{dfup_pkg::OP_SET,  8'h3C,              8'h20, 8'h02, NO_RESULT,  RES_NONE},
        '{dfup_pkg::OP_BYTE, 8'h78,              8'h00, 8'h00, BY_MODEL,   RES_NONE},
        '{dfup_pkg::OP_BYTE, 8'h9A,              8'h00, 8'h00, BY_MODEL,   RES_NONE},
        '{dfup_pkg::OP_BYTE, 8'hBC,              8'h00, 8'h00, BY_MODEL,   RES_NONE},
        '{dfup_pkg::OP_BYTE, dfup_pkg::ETX_BYTE, 8'h00, 8'h00, ONE_RESULT, RES_ALT},
        '{dfup_pkg::OP_BYTE, 8'h00,              8'hC3, 8'h3C, BY_MODEL,   RES_NONE}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_op = dfup_pkg::OP_BYTE;
    logic [7:0]  i_rx_byte = 8'h00;
    logic [7:0]  i_cmd_id = 8'h00;
    logic [7:0]  i_cmd_length = 8'h00;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_kind;
    logic [31:0] o_word_a;
    logic [31:0] o_word_b;
    logic [31:0] o_word_c;
    logic [15:0] o_week;
    logic [7:0]  o_command_byte;
    logic        o_command_known;
    logic        o_last;

    t_parse_state   parse_state = ST_HUNT;
    int             body_fill = 0;
    bit [7:0]       body_bytes [16];
    bit [7:0]       command_buf [CMD_BYTES];
    int             command_fill = 0;
    bit             length_known [dfup_pkg::TABLE_ENTRIES];
    bit [7:0]       length_value [dfup_pkg::TABLE_ENTRIES];
    t_uplink_result byte_results [$];
    t_uplink_result results_due [$];
    t_uplink_result awaited;
    logic [7:0]     line_q [$];

    bit sender_steady = 1'b0;
    bit hold_requested = 1'b0;
    int hold_left = 0;
    int pause_left = 0;
    int run_left = 0;
    int holds_done = 0;
    int items_sent = 0;
    int results_seen = 0;
    int mismatch_count = 0;
    int kind_count [5];
    int command_run = 0;
    int longest_command = 0;
    int idle_cycles = 0;

    dle_framed_uplink_parser_unit i_dut (.*);

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    function automatic logic [31:0] le32(input int at);
        return {body_bytes[at + 3], body_bytes[at + 2], body_bytes[at + 1], body_bytes[at]};
    endfunction

    function automatic logic [31:0] be16(input int at);
        return {16'h0, body_bytes[at], body_bytes[at + 1]};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 15);
        if (r < 2) return dfup_pkg::DLE_BYTE;
        if (r == 2) return dfup_pkg::ETX_BYTE;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_cmd_id();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'h20;
            2: return 8'h21;
            3: return 8'h22;
            4: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("Mismatch on result %0d: %s is %h, expected %h.", results_seen, what, got,
                     want);
    endtask

    // Behavioural parser: consumes one item and leaves its results in byte_results.
    task automatic advance_parser(input logic op, input logic [7:0] rx, input logic [7:0] id,
                                  input logic [7:0] len);
        t_parse_state   done_state;
        t_uplink_result res;
        int             body_size;
        logic [7:0]     lead;
        byte_results.delete();
        if (op == dfup_pkg::OP_SET) begin
            length_known[id] = 1'b1;
            length_value[id] = len;
        end else begin
            case (parse_state)
                ST_HUNT: begin
                    if (rx == dfup_pkg::DLE_BYTE) parse_state = ST_ID;
                end
                ST_ID: begin
                    body_fill = 0;
                    case (rx)
                        dfup_pkg::ID_POS:  parse_state = ST_POSITION;
                        dfup_pkg::ID_TIME: parse_state = ST_TIME;
                        dfup_pkg::ID_ALT:  parse_state = ST_ALT;
                        dfup_pkg::ID_REQ:  parse_state = ST_REQUEST;
                        dfup_pkg::ID_CMD:  parse_state = ST_FRAGMENT;
                        default: parse_state = ST_HUNT;
                    endcase
                end
                default: begin
                    body_bytes[body_fill] = rx;
                    body_fill++;
                    case (parse_state)
                        ST_POSITION, ST_TIME: body_size = 15;
                        ST_ALT: body_size = 7;
                        ST_REQUEST: body_size = 1;
                        default: body_size = 4;
                    endcase
                    if (body_fill == body_size) begin
                        done_state = parse_state;
                        parse_state = ST_HUNT;
                        body_fill = 0;
                        res = '0;
                        res.last = 1'b1;
                        if (rx == dfup_pkg::ETX_BYTE) begin
                            case (done_state)
                                ST_POSITION: begin
                                    res.kind = dfup_pkg::KIND_POS;
                                    res.word_a = le32(0);
                                    res.word_b = le32(4);
                                    res.word_c = le32(8);
                                    byte_results.push_back(res);
                                end
                                ST_TIME: begin
                                    res.kind = dfup_pkg::KIND_TIME;
                                    res.word_a = le32(0);
                                    res.word_b = le32(6);
                                    res.word_c = le32(10);
                                    res.week = {body_bytes[5], body_bytes[4]};
                                    byte_results.push_back(res);
                                end
                                ST_ALT: begin
                                    res.kind = dfup_pkg::KIND_ALT;
                                    res.word_a = be16(0);
                                    res.word_b = be16(2);
                                    res.word_c = be16(4);
                                    byte_results.push_back(res);
                                end
                                ST_REQUEST: begin
                                    res.kind = dfup_pkg::KIND_REQ;
                                    byte_results.push_back(res);
                                end
                                default: begin
                                    if (int'(body_bytes[1]) != command_fill ||
                                        command_fill >= CMD_BYTES) begin
                                        command_fill = 0;
                                    end else begin
                                        command_buf[command_fill] = body_bytes[2];
                                        command_fill++;
                                        lead = command_buf[0];
                                        if (!length_known[lead] ||
                                            int'(length_value[lead]) == command_fill) begin
                                            for (int k = 0; k < command_fill; k++) begin
                                                res = '0;
                                                res.kind = dfup_pkg::KIND_CMD;
                                                res.command_byte = command_buf[k];
                                                res.command_known = length_known[lead];
                                                res.last = (k == command_fill - 1);
                                                byte_results.push_back(res);
                                            end
                                            command_fill = 0;
                                        end
                                    end
                                end
                            endcase
                        end
                    end
                end
            endcase
        end
    endtask

    task automatic offer_item(input logic op, input logic [7:0] rx, input logic [7:0] id,
                              input logic [7:0] len, input t_expect_mode mode,
                              input t_uplink_result typed);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_rx_byte <= rx;
        i_cmd_id <= id;
        i_cmd_length <= len;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        advance_parser(op, rx, id, len);
        case (mode)
            BY_MODEL: foreach (byte_results[k]) results_due.push_back(byte_results[k]);
            ONE_RESULT: results_due.push_back(typed);
            default: ;
        endcase
    endtask

    task automatic flush_line();
        while (line_q.size() > 0)
            offer_item(dfup_pkg::OP_BYTE, line_q.pop_front(), 8'($urandom), 8'($urandom),
                       BY_MODEL, '0);
    endtask

    task automatic send_frame(input logic [7:0] id, input int size);
        line_q.push_back(dfup_pkg::DLE_BYTE);
        line_q.push_back(id);
        repeat (size - 1) line_q.push_back(rand_byte());
        line_q.push_back(($urandom_range(0, 9) == 0) ? rand_byte() : dfup_pkg::ETX_BYTE);
        flush_line();
    endtask

    task automatic send_fragment(input logic [7:0] len, input logic [7:0] seq,
                                 input logic [7:0] cb, input logic [7:0] fin);
        line_q.push_back(dfup_pkg::DLE_BYTE);
        line_q.push_back(dfup_pkg::ID_CMD);
        line_q.push_back(len);
        line_q.push_back(seq);
        line_q.push_back(cb);
        line_q.push_back(fin);
        flush_line();
    endtask

    task automatic send_command(input logic [7:0] cid, input int nfrag, input bit clean);
        logic [7:0] seq;
        logic [7:0] cb;
        logic [7:0] fin;
        for (int k = 0; k < nfrag; k++) begin
            seq = 8'(command_fill);
            if (!clean && $urandom_range(0, 9) == 0) seq = 8'($urandom);
            cb = (command_fill == 0) ? cid : rand_byte();
            fin = (!clean && $urandom_range(0, 15) == 0) ? rand_byte() : dfup_pkg::ETX_BYTE;
            send_fragment(8'($urandom), seq, cb, fin);
        end
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_requested) begin
                hold_left = HOLD_CYCLES;
                hold_requested = 1'b0;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (pause_left > 0) begin
                pause_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (run_left > 0) begin
                    run_left--;
                end else begin
                    pause_left = pick_gap();
                    run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                          : $urandom_range(0, 8);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (o_kind <= dfup_pkg::KIND_CMD) kind_count[o_kind]++;
            if (o_kind == dfup_pkg::KIND_CMD) begin
                command_run++;
                if (o_last) begin
                    if (command_run > longest_command) longest_command = command_run;
                    command_run = 0;
                end
            end
            if (results_due.size() == 0) begin
                report_mismatch("result with nothing outstanding, kind", 32'(o_kind), 32'h0);
            end else begin
                awaited = results_due.pop_front();
                if (o_kind !== awaited.kind)
                    report_mismatch("kind", 32'(o_kind), 32'(awaited.kind));
                if (o_word_a !== awaited.word_a)
                    report_mismatch("word_a", o_word_a, awaited.word_a);
                if (o_word_b !== awaited.word_b)
                    report_mismatch("word_b", o_word_b, awaited.word_b);
                if (o_word_c !== awaited.word_c)
                    report_mismatch("word_c", o_word_c, awaited.word_c);
                if (o_week !== awaited.week)
                    report_mismatch("week", 32'(o_week), 32'(awaited.week));
                if (o_command_byte !== awaited.command_byte)
                    report_mismatch("command_byte", 32'(o_command_byte),
                                    32'(awaited.command_byte));
                if (o_command_known !== awaited.command_known)
                    report_mismatch("command_known", 32'(o_command_known),
                                    32'(awaited.command_known));
                if (o_last !== awaited.last)
                    report_mismatch("last", 32'(o_last), 32'(awaited.last));
            end
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog expired with %0d results outstanding.", results_due.size());
        $display("dle_framed_uplink_parser_unit_tb failed");
        $finish;
    end

    initial begin
        int         r;
        int         nfrag;
        bit         long_done;
        logic [7:0] cid;
        long_done = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[k])
            offer_item(DIRECTED_ROWS[k].op, DIRECTED_ROWS[k].rx_byte, DIRECTED_ROWS[k].cmd_id,
                       DIRECTED_ROWS[k].cmd_length, DIRECTED_ROWS[k].mode,
                       DIRECTED_ROWS[k].result);

        while (items_sent < TOTAL_ITEMS) begin
            sender_steady = ($urandom_range(0, 3) == 0);
            if (!long_done && items_sent >= TOTAL_ITEMS / 2) begin
                // A long known command, then a burst of requests against a stalled receiver.
                sender_steady = 1'b1;
                if (command_fill != 0)
                    send_fragment(rand_byte(), 8'hEE, rand_byte(), dfup_pkg::ETX_BYTE);
                offer_item(dfup_pkg::OP_SET, 8'($urandom), 8'hC3, 8'(LONG_FRAGMENTS),
                           BY_MODEL, '0);
                send_command(8'hC3, LONG_FRAGMENTS, 1'b1);
                hold_requested = 1'b1;
                repeat (6) send_frame(dfup_pkg::ID_REQ, 1);
                long_done = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    send_frame(dfup_pkg::ID_POS, 15);
                end else if (r < 24) begin
                    send_frame(dfup_pkg::ID_TIME, 15);
                end else if (r < 34) begin
                    send_frame(dfup_pkg::ID_ALT, 7);
                end else if (r < 42) begin
                    send_frame(dfup_pkg::ID_REQ, 1);
                end else if (r < 72) begin
                    cid = pick_cmd_id();
                    if (length_known[cid] && length_value[cid] != 0 && length_value[cid] <= 6)
                        nfrag = int'(length_value[cid]);
                    else
                        nfrag = $urandom_range(1, 3);
                    send_command(cid, nfrag, 1'b0);
                end else if (r < 82) begin
                    case ($urandom_range(0, 9))
                        0: nfrag = 0;
                        1: nfrag = 255;
                        2: nfrag = $urandom_range(0, 255);
                        default: nfrag = $urandom_range(1, 5);
                    endcase
                    offer_item(dfup_pkg::OP_SET, 8'($urandom), pick_cmd_id(), 8'(nfrag),
                               BY_MODEL, '0);
                end else if (r < 92) begin
                    repeat ($urandom_range(1, 4)) line_q.push_back(rand_byte());
                    flush_line();
                end else begin
                    line_q.push_back(dfup_pkg::DLE_BYTE);
                    line_q.push_back(8'($urandom));
                    flush_line();
                end
            end
        end
        i_valid <= 1'b0;

        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d items and %0d results: %0d position, %0d time, %0d altitude,",
                 items_sent, results_seen, kind_count[0], kind_count[1], kind_count[2]);
        $display("%0d request, %0d command bytes (longest command %0d), %0d long hold-off(s).",
                 kind_count[3], kind_count[4], longest_command, holds_done);
        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("dle_framed_uplink_parser_unit_tb passed");
        end else begin
            $display("%0d mismatches found.", mismatch_count);
            $display("dle_framed_uplink_parser_unit_tb failed");
        end
        $finish;
    end

endmodule
